// ===== src/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tcw_pkg
// Types and constants shared by the text console cell writer modules.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int CFG_IDX_W = 1;
  localparam int COLOR_W   = 4;

  localparam logic [CFG_IDX_W-1:0] REG_TEXT_COLOR = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BG_COLOR   = 1'd1;

  localparam logic [COLOR_W-1:0] TEXT_COLOR_RESET = 4'hF;
  localparam logic [COLOR_W-1:0] BG_COLOR_RESET   = 4'h0;

  localparam logic [7:0]  CH_NEWLINE = 8'd10;
  localparam logic [7:0]  CH_RETURN  = 8'd13;
  localparam logic [15:0] FG_MASK    = 16'h0F00;
  localparam logic [15:0] BG_MASK    = 16'hF000;
  localparam logic [15:0] RESET_CELL = 16'h0F00;

  typedef enum logic [2:0] {
    REQ_PUT    = 3'd0,
    REQ_CLEAR  = 3'd1,
    REQ_FG     = 3'd2,
    REQ_BG     = 3'd3,
    REQ_SETCUR = 3'd4,
    REQ_READ   = 3'd5
  } req_code_t;

  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] char_code;
    logic [6:0] col;
    logic [4:0] row;
  } req_t;

  typedef struct packed {
    logic [6:0]  cursor_col;
    logic [4:0]  cursor_row;
    logic [10:0] cursor_pos;
    logic [15:0] cell_data;
  } res_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_COPY,
    ST_SWEEP,
    ST_SETCUR,
    ST_READ,
    ST_RDATA
  } state_t;

  typedef enum logic [2:0] {
    SW_INIT,
    SW_CLEAR,
    SW_BLANK_ROW,
    SW_COPY,
    SW_FG,
    SW_BG
  } sweep_mode_t;

  typedef enum logic [1:0] {
    CUR_HOLD,
    CUR_HOME,
    CUR_LOAD,
    CUR_ADVANCE
  } cursor_op_t;

  typedef struct packed {
    logic        latch;
    cursor_op_t  cur_op;
    logic        put;
    logic        sweep_start;
    sweep_mode_t sweep_mode;
    logic        sweep_run;
    logic        rd_cell;
    logic        emit;
    logic        emit_data;
  } ctrl_cmd_t;

  typedef struct packed {
    req_code_t req;
    logic      need_scroll;
    logic      sweep_done;
  } ctrl_status_t;

endpackage

// ===== src/text_console_cell_writer_top.sv =====
// ----------------------------------------------------------------------------
// text_console_cell_writer_top
// Text console with a cell memory of COLS x ROWS cells and a cursor.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; its result appears on
// out_res for exactly one cycle with out_valid high and cannot be held off.
// After reset the block is busy while it fills the cell memory with blank
// white-on-black cells; configuration writes are accepted at any time.
// Timing is set by the single-port-per-direction cell memory: clear and
// recolor sweep every cell, and an item that scrolls first copies the screen
// up a row (one cell moved per cycle) and then blanks the last row.
module text_console_cell_writer_top #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  tcw_pkg::req_t                 in_req,
  output logic                          out_valid,
  output tcw_pkg::res_t                 out_res,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tcw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tcw_pkg::COLOR_W-1:0]   cfg_data
);

  tcw_pkg::ctrl_cmd_t    cmd;
  tcw_pkg::ctrl_status_t status;

  assign cfg_ready = 1'b1;

  tcw_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  tcw_datapath #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  // Every result comes out of a cycle in which an item was being worked on.
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without an item in progress");

  // An accepted item keeps the block busy in the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("block not busy after accepting an item");

  // One item gives exactly one result, so results never come back to back.
  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("two results in consecutive cycles");

endmodule

// ===== src/tcw_ctrl.sv =====
// ----------------------------------------------------------------------------
// tcw_ctrl
// Sequencer of the console: decodes the held item and steps the datapath.
// ----------------------------------------------------------------------------
module tcw_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  tcw_pkg::ctrl_status_t status,
  output tcw_pkg::ctrl_cmd_t    cmd
);

  tcw_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tcw_pkg::ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != tcw_pkg::ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tcw_pkg::ST_INIT: begin
        if (status.sweep_done) state_nxt = tcw_pkg::ST_IDLE;
      end
      tcw_pkg::ST_IDLE: begin
        if (start) state_nxt = tcw_pkg::ST_EXEC;
      end
      tcw_pkg::ST_EXEC: begin
        unique case (status.req) inside
          tcw_pkg::REQ_PUT: begin
            state_nxt = status.need_scroll ? tcw_pkg::ST_COPY : tcw_pkg::ST_IDLE;
          end
          tcw_pkg::REQ_CLEAR, tcw_pkg::REQ_FG, tcw_pkg::REQ_BG: begin
            state_nxt = tcw_pkg::ST_SWEEP;
          end
          tcw_pkg::REQ_SETCUR: state_nxt = tcw_pkg::ST_SETCUR;
          tcw_pkg::REQ_READ:   state_nxt = tcw_pkg::ST_READ;
          default:             state_nxt = tcw_pkg::ST_IDLE;
        endcase
      end
      tcw_pkg::ST_COPY: begin
        if (status.sweep_done) state_nxt = tcw_pkg::ST_SWEEP;
      end
      tcw_pkg::ST_SWEEP: begin
        if (status.sweep_done) state_nxt = tcw_pkg::ST_IDLE;
      end
      tcw_pkg::ST_SETCUR: state_nxt = tcw_pkg::ST_IDLE;
      tcw_pkg::ST_READ:   state_nxt = tcw_pkg::ST_RDATA;
      tcw_pkg::ST_RDATA:  state_nxt = tcw_pkg::ST_IDLE;
      default:            state_nxt = tcw_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd             = '0;
    cmd.cur_op      = tcw_pkg::CUR_HOLD;
    cmd.sweep_mode  = tcw_pkg::SW_CLEAR;
    unique case (state_r)
      tcw_pkg::ST_INIT: cmd.sweep_run = 1'b1;
      tcw_pkg::ST_IDLE: cmd.latch = start;
      tcw_pkg::ST_EXEC: begin
        unique case (status.req) inside
          tcw_pkg::REQ_PUT: begin
            cmd.cur_op = tcw_pkg::CUR_ADVANCE;
            cmd.put    = 1'b1;
            if (status.need_scroll) begin
              cmd.sweep_start = 1'b1;
              cmd.sweep_mode  = tcw_pkg::SW_COPY;
            end else begin
              cmd.emit = 1'b1;
            end
          end
          tcw_pkg::REQ_CLEAR: begin
            cmd.cur_op      = tcw_pkg::CUR_HOME;
            cmd.sweep_start = 1'b1;
            cmd.sweep_mode  = tcw_pkg::SW_CLEAR;
          end
          tcw_pkg::REQ_FG: begin
            cmd.sweep_start = 1'b1;
            cmd.sweep_mode  = tcw_pkg::SW_FG;
          end
          tcw_pkg::REQ_BG: begin
            cmd.sweep_start = 1'b1;
            cmd.sweep_mode  = tcw_pkg::SW_BG;
          end
          tcw_pkg::REQ_SETCUR, tcw_pkg::REQ_READ: begin
            cmd.emit = 1'b0;
          end
          default: cmd.emit = 1'b1;
        endcase
      end
      tcw_pkg::ST_COPY: begin
        cmd.sweep_run = 1'b1;
        if (status.sweep_done) begin
          cmd.sweep_start = 1'b1;
          cmd.sweep_mode  = tcw_pkg::SW_BLANK_ROW;
        end
      end
      tcw_pkg::ST_SWEEP: begin
        cmd.sweep_run = 1'b1;
        cmd.emit      = status.sweep_done;
      end
      tcw_pkg::ST_SETCUR: begin
        cmd.cur_op = tcw_pkg::CUR_LOAD;
        cmd.emit   = 1'b1;
      end
      tcw_pkg::ST_READ: cmd.rd_cell = 1'b1;
      tcw_pkg::ST_RDATA: begin
        cmd.emit      = 1'b1;
        cmd.emit_data = 1'b1;
      end
      default: cmd.emit = 1'b0;
    endcase
  end

endmodule

// ===== src/tcw_datapath.sv =====
// ----------------------------------------------------------------------------
// tcw_datapath
// Cell memory, cursor, color registers, sweep engine and result register.
// ----------------------------------------------------------------------------
module tcw_datapath #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  tcw_pkg::req_t                       in_req,
  input  logic                                cfg_we,
  input  logic [tcw_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tcw_pkg::COLOR_W-1:0]         cfg_data,
  input  tcw_pkg::ctrl_cmd_t                  cmd,
  output tcw_pkg::ctrl_status_t               status,
  output logic                                out_valid,
  output tcw_pkg::res_t                       out_res
);

  localparam int CELLS = COLS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int KW    = $clog2(CELLS + 1);
  localparam int CW    = $clog2(COLS);
  localparam int RW    = $clog2(ROWS);

  logic [tcw_pkg::COLOR_W-1:0] text_color_r, bg_color_r;
  tcw_pkg::req_t               req_r;
  logic [CW-1:0]               col_r, col_nxt, col_cl, col_cl_r;
  logic [RW-1:0]               row_r, row_nxt, row_cl, row_cl_r;
  logic [AW-1:0]               pos_r, pos_nxt, idx_r;
  logic [KW-1:0]               cnt_r, cnt_limit, rd_off;
  tcw_pkg::sweep_mode_t        sw_mode_r;
  logic [15:0]                 mem [CELLS];
  logic [15:0]                 rdata_r, wdata, blank, put_cell;
  logic [AW-1:0]               waddr, raddr;
  logic                        we;
  logic                        is_nl, is_cr, last_col, last_row;
  logic                        out_valid_r;
  tcw_pkg::res_t               out_res_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_color_r <= tcw_pkg::TEXT_COLOR_RESET;
      bg_color_r   <= tcw_pkg::BG_COLOR_RESET;
    end else if (cfg_we) begin
      if (cfg_index == tcw_pkg::REG_TEXT_COLOR) begin
        text_color_r <= cfg_data;
      end else if (cfg_index == tcw_pkg::REG_BG_COLOR) begin
        bg_color_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) req_r <= in_req;
  end

  assign blank    = {bg_color_r, text_color_r, 8'h00};
  assign put_cell = {bg_color_r, text_color_r, req_r.char_code};

  // Saturated coordinates and their linear index, registered before use.
  always_comb begin
    col_cl = (int'(req_r.col) > COLS - 1) ? CW'(COLS - 1) : CW'(req_r.col);
    row_cl = (int'(req_r.row) > ROWS - 1) ? RW'(ROWS - 1) : RW'(req_r.row);
  end

  always_ff @(posedge clk) begin
    col_cl_r <= col_cl;
    row_cl_r <= row_cl;
    idx_r    <= AW'(AW'(row_cl) * AW'(COLS)) + AW'(col_cl);
  end

  assign is_nl    = (req_r.char_code == tcw_pkg::CH_NEWLINE);
  assign is_cr    = (req_r.char_code == tcw_pkg::CH_RETURN);
  assign last_col = (col_r == CW'(COLS - 1));
  assign last_row = (row_r == RW'(ROWS - 1));

  // A newline on the last row, or a character in the last cell, scrolls.
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    pos_nxt = pos_r;
    unique case (cmd.cur_op)
      tcw_pkg::CUR_HOLD: begin
        pos_nxt = pos_r;
      end
      tcw_pkg::CUR_HOME: begin
        col_nxt = '0;
        row_nxt = '0;
        pos_nxt = '0;
      end
      tcw_pkg::CUR_LOAD: begin
        col_nxt = col_cl_r;
        row_nxt = row_cl_r;
        pos_nxt = idx_r;
      end
      tcw_pkg::CUR_ADVANCE: begin
        if (is_nl) begin
          if (!last_row) begin
            row_nxt = row_r + RW'(1);
            pos_nxt = pos_r + AW'(COLS);
          end
        end else if (is_cr) begin
          col_nxt = '0;
          pos_nxt = pos_r - AW'(col_r);
        end else if (last_col) begin
          col_nxt = '0;
          if (last_row) begin
            pos_nxt = pos_r - AW'(COLS - 1);
          end else begin
            row_nxt = row_r + RW'(1);
            pos_nxt = pos_r + AW'(1);
          end
        end else begin
          col_nxt = col_r + CW'(1);
          pos_nxt = pos_r + AW'(1);
        end
      end
      default: pos_nxt = pos_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      pos_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      pos_r <= pos_nxt;
    end
  end

  // Sweep engine. Fill modes write one cell per cycle; the read-modify
  // modes read one cell ahead and write it back in the following cycle.
  always_comb begin
    unique case (sw_mode_r) inside
      tcw_pkg::SW_INIT, tcw_pkg::SW_CLEAR: cnt_limit = KW'(CELLS - 1);
      tcw_pkg::SW_BLANK_ROW:               cnt_limit = KW'(COLS - 1);
      tcw_pkg::SW_COPY:                    cnt_limit = KW'(CELLS - COLS);
      default:                             cnt_limit = KW'(CELLS);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      sw_mode_r <= tcw_pkg::SW_INIT;
    end else if (cmd.sweep_start) begin
      cnt_r     <= '0;
      sw_mode_r <= cmd.sweep_mode;
    end else if (cmd.sweep_run) begin
      cnt_r <= cnt_r + KW'(1);
    end
  end

  assign rd_off = (sw_mode_r == tcw_pkg::SW_COPY) ? KW'(COLS) : '0;
  assign raddr  = cmd.rd_cell ? idx_r : AW'(cnt_r + rd_off);

  always_comb begin
    we    = 1'b0;
    waddr = pos_r;
    wdata = put_cell;
    if (cmd.put && !is_nl && !is_cr) begin
      we = 1'b1;
    end else if (cmd.sweep_run) begin
      case (sw_mode_r) inside
        tcw_pkg::SW_INIT: begin
          we    = 1'b1;
          waddr = cnt_r[AW-1:0];
          wdata = tcw_pkg::RESET_CELL;
        end
        tcw_pkg::SW_CLEAR: begin
          we    = 1'b1;
          waddr = cnt_r[AW-1:0];
          wdata = blank;
        end
        tcw_pkg::SW_BLANK_ROW: begin
          we    = 1'b1;
          waddr = AW'(CELLS - COLS) + cnt_r[AW-1:0];
          wdata = blank;
        end
        tcw_pkg::SW_COPY: begin
          we    = (cnt_r != '0);
          waddr = AW'(cnt_r - KW'(1));
          wdata = rdata_r;
        end
        tcw_pkg::SW_FG: begin
          we    = (cnt_r != '0);
          waddr = AW'(cnt_r - KW'(1));
          wdata = (rdata_r & ~tcw_pkg::FG_MASK) | {4'h0, text_color_r, 8'h00};
        end
        default: begin
          we    = (cnt_r != '0);
          waddr = AW'(cnt_r - KW'(1));
          wdata = (rdata_r & ~tcw_pkg::BG_MASK) | {bg_color_r, 12'h000};
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  assign status.req         = tcw_pkg::req_code_t'(req_r.req_type);
  assign status.need_scroll = (is_nl && last_row) ||
                              (!is_nl && !is_cr && last_col && last_row);
  assign status.sweep_done  = (cnt_r == cnt_limit);

  // Result register: the cursor fields come from the values being stored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_res_r.cursor_col <= 7'(col_nxt);
      out_res_r.cursor_row <= 5'(row_nxt);
      out_res_r.cursor_pos <= 11'(pos_nxt);
      out_res_r.cell_data  <= cmd.emit_data ? rdata_r : 16'h0000;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

// ===== verif/tb_text_console_cell_writer_top.sv =====
// ----------------------------------------------------------------------------
// tb_text_console_cell_writer_top
// Self-checking testbench for the text console cell writer. A behavioral
// model of the cell memory, cursor and color registers predicts every result.
// Directed items cover wrap, scroll, clamping and full-screen sweeps. Random
// typing, probing and recolor sequences then run under several color settings.
// ----------------------------------------------------------------------------
module tb_text_console_cell_writer_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COLS        = 80;
  localparam int ROWS        = 25;
  localparam int CELLS       = COLS * ROWS;
  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 152;

  // Request codes that the block decodes as no operation.
  localparam logic [2:0] REQ_SPARE_LO = 3'd6;
  localparam logic [2:0] REQ_SPARE_HI = 3'd7;

  class console_scoreboard;
    logic [15:0]   cells [CELLS];
    int unsigned   cursor;
    logic [3:0]    fg;
    logic [3:0]    bg;
    tcw_pkg::res_t expected_reports [$];
    int unsigned   mismatches;
    int unsigned   reports_seen;
    int unsigned   scrolls;
    int unsigned   sweeps;
    int unsigned   reads;
    int unsigned   clamps;
    int unsigned   color_writes;

    function new();
      fg           = tcw_pkg::TEXT_COLOR_RESET;
      bg           = tcw_pkg::BG_COLOR_RESET;
      cursor       = 0;
      mismatches   = 0;
      reports_seen = 0;
      scrolls      = 0;
      sweeps       = 0;
      reads        = 0;
      clamps       = 0;
      color_writes = 0;
      foreach (cells[i]) cells[i] = tcw_pkg::RESET_CELL;
    endfunction

    function int unsigned pending();
      return expected_reports.size();
    endfunction

    function logic [15:0] blank_cell();
      return {bg, fg, 8'h00};
    endfunction

    function void scroll_up();
      logic [15:0] blank;
      blank = blank_cell();
      for (int i = 0; i < CELLS - COLS; i++) cells[i] = cells[i + COLS];
      for (int i = CELLS - COLS; i < CELLS; i++) cells[i] = blank;
      scrolls++;
    endfunction

    function int unsigned clamped_index(logic [6:0] c, logic [4:0] r);
      int unsigned cc;
      int unsigned rr;
      cc = (c > COLS - 1) ? COLS - 1 : c;
      rr = (r > ROWS - 1) ? ROWS - 1 : r;
      if (c > COLS - 1 || r > ROWS - 1) clamps++;
      return rr * COLS + cc;
    endfunction

    function void write_reg(logic [tcw_pkg::CFG_IDX_W-1:0] idx,
                            logic [tcw_pkg::COLOR_W-1:0] val);
      color_writes++;
      if (idx == tcw_pkg::REG_TEXT_COLOR) begin
        fg = val;
      end else if (idx == tcw_pkg::REG_BG_COLOR) begin
        bg = val;
      end
    endfunction

    function void note_request(tcw_pkg::req_t r);
      logic [15:0]   data;
      tcw_pkg::res_t rep;
      data = '0;
      case (r.req_type)
        tcw_pkg::REQ_PUT: begin
          if (r.char_code == tcw_pkg::CH_NEWLINE) begin
            cursor += COLS;
          end else if (r.char_code == tcw_pkg::CH_RETURN) begin
            cursor -= cursor % COLS;
          end else begin
            cells[cursor] = blank_cell() | {8'h00, r.char_code};
            cursor++;
          end
          // Running off the bottom scrolls and keeps the cursor on the last row.
          if (cursor >= CELLS) begin
            cursor -= COLS;
            scroll_up();
          end
        end
        tcw_pkg::REQ_CLEAR: begin
          cursor = 0;
          foreach (cells[i]) cells[i] = blank_cell();
          sweeps++;
        end
        tcw_pkg::REQ_FG: begin
          foreach (cells[i])
            cells[i] = (cells[i] & ~tcw_pkg::FG_MASK) | {4'h0, fg, 8'h00};
          sweeps++;
        end
        tcw_pkg::REQ_BG: begin
          foreach (cells[i])
            cells[i] = (cells[i] & ~tcw_pkg::BG_MASK) | {bg, 12'h000};
          sweeps++;
        end
        tcw_pkg::REQ_SETCUR: cursor = clamped_index(r.col, r.row);
        tcw_pkg::REQ_READ: begin
          data = cells[clamped_index(r.col, r.row)];
          reads++;
        end
        default: ;
      endcase
      rep.cursor_col = 7'(cursor % COLS);
      rep.cursor_row = 5'(cursor / COLS);
      rep.cursor_pos = 11'(cursor);
      rep.cell_data  = data;
      expected_reports.push_back(rep);
    endfunction

    function void compare_field(string what, int unsigned want, int unsigned got);
      if (want != got) begin
        mismatches++;
        $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
      end
    endfunction

    function void check_result(tcw_pkg::res_t got);
      tcw_pkg::res_t want;
      reports_seen++;
      if (expected_reports.size() == 0) begin
        mismatches++;
        $display("%0t: result expected none, got %h", $time, got);
        return;
      end
      want = expected_reports.pop_front();
      compare_field("cursor_col", want.cursor_col, got.cursor_col);
      compare_field("cursor_row", want.cursor_row, got.cursor_row);
      compare_field("cursor_pos", want.cursor_pos, got.cursor_pos);
      compare_field("cell_data", want.cell_data, got.cell_data);
    endfunction
  endclass

  logic                          clk;
  logic                          rst_n;
  logic                          start;
  logic                          busy;
  tcw_pkg::req_t                 in_req;
  logic                          out_valid;
  tcw_pkg::res_t                 out_res;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [tcw_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [tcw_pkg::COLOR_W-1:0]   cfg_data;

  console_scoreboard sb;
  int unsigned       items_sent;
  bit                gaps_on;

  text_console_cell_writer_top #(
    .COLS(COLS),
    .ROWS(ROWS)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_res  (out_res),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Results are checked before the item of the same edge is noted, so a
  // result can never be matched against an item accepted in the same cycle.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) sb.check_result(out_res);
      if (start && !busy) sb.note_request(in_req);
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
    end
  end

  task automatic issue(input logic [2:0] code, input logic [7:0] ch,
                       input logic [6:0] c, input logic [4:0] r);
    tcw_pkg::req_t item;
    item.req_type  = code;
    item.char_code = ch;
    item.col       = c;
    item.row       = r;
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    start  <= 1'b1;
    in_req <= item;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0 || busy);
  endtask

  task automatic write_reg(input logic [tcw_pkg::CFG_IDX_W-1:0] idx,
                           input logic [tcw_pkg::COLOR_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_colors(input logic [3:0] text, input logic [3:0] back);
    write_reg(tcw_pkg::REG_TEXT_COLOR, text);
    write_reg(tcw_pkg::REG_BG_COLOR, back);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [6:0] pick_col();
    return ($urandom_range(0, 6) == 0) ? 7'($urandom_range(0, 127))
                                       : 7'($urandom_range(0, COLS - 1));
  endfunction

  function automatic logic [4:0] pick_row();
    return ($urandom_range(0, 6) == 0) ? 5'($urandom_range(0, 31))
                                       : 5'($urandom_range(0, ROWS - 1));
  endfunction

  task automatic run_sequence();
    int unsigned kind;
    int unsigned pick;
    int unsigned row_now;
    logic [7:0]  ch;
    kind = $urandom_range(0, 99);
    if (kind < 60) begin
      // A line of text, usually at a fresh cursor position.
      if ($urandom_range(0, 2) != 0)
        issue(tcw_pkg::REQ_SETCUR, 8'($urandom), pick_col(), pick_row());
      repeat ($urandom_range(1, 24)) begin
        pick = $urandom_range(0, 99);
        ch = (pick < 8)  ? tcw_pkg::CH_NEWLINE :
             (pick < 14) ? tcw_pkg::CH_RETURN  : 8'($urandom_range(0, 255));
        issue(tcw_pkg::REQ_PUT, ch, 7'($urandom), 5'($urandom));
      end
    end else if (kind < 85) begin
      // Probe cells, half of them near the text just written.
      repeat ($urandom_range(1, 6)) begin
        row_now = sb.cursor / COLS;
        if (row_now > 0 && $urandom_range(0, 1) == 1) row_now--;
        if ($urandom_range(0, 1) == 1) begin
          issue(tcw_pkg::REQ_READ, 8'($urandom), pick_col(), pick_row());
        end else begin
          issue(tcw_pkg::REQ_READ, 8'($urandom), 7'($urandom_range(0, COLS - 1)),
                5'(row_now));
        end
      end
    end else if (kind < 93) begin
      issue(3'($urandom_range(0, 7)), 8'($urandom), 7'($urandom), 5'($urandom));
    end else begin
      case ($urandom_range(0, 4))
        0: issue(tcw_pkg::REQ_CLEAR, 8'($urandom), 7'($urandom), 5'($urandom));
        1: issue(tcw_pkg::REQ_FG, 8'($urandom), 7'($urandom), 5'($urandom));
        2: issue(tcw_pkg::REQ_BG, 8'($urandom), 7'($urandom), 5'($urandom));
        3: begin
          issue(tcw_pkg::REQ_SETCUR, 8'($urandom), 7'($urandom_range(0, COLS - 1)),
                5'(ROWS - 1));
          issue(tcw_pkg::REQ_PUT, tcw_pkg::CH_NEWLINE, 7'($urandom), 5'($urandom));
        end
        default: begin
          // Type across the last cell so the screen scrolls on wrap.
          issue(tcw_pkg::REQ_SETCUR, 8'($urandom), 7'(COLS - $urandom_range(1, 6)),
                5'(ROWS - 1));
          repeat (8)
            issue(tcw_pkg::REQ_PUT, 8'($urandom_range(32, 126)), 7'($urandom),
                  5'($urandom));
        end
      endcase
    end
  endtask

  initial begin
    int unsigned target;
    int          p;
    sb         = new();
    items_sent = 0;
    gaps_on    = 1'b0;
    rst_n      = 1'b0;
    start      = 1'b0;
    in_req     = '0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Reset colors: cursor movement, wrap and scroll, clamping, spare codes.
    gaps_on = 1'b1;
    issue(tcw_pkg::REQ_READ, 8'h00, 7'd0, 5'd0);
    issue(tcw_pkg::REQ_PUT, 8'h41, 7'd0, 5'd0);
    issue(tcw_pkg::REQ_PUT, 8'hFF, 7'h7F, 5'h1F);
    issue(tcw_pkg::REQ_PUT, 8'h00, 7'd0, 5'd0);
    issue(tcw_pkg::REQ_PUT, tcw_pkg::CH_RETURN, 7'd0, 5'd0);
    issue(tcw_pkg::REQ_PUT, tcw_pkg::CH_NEWLINE, 7'd0, 5'd0);
    issue(tcw_pkg::REQ_READ, 8'h00, 7'd1, 5'd0);
    issue(tcw_pkg::REQ_READ, 8'hFF, 7'd2, 5'd0);
    issue(tcw_pkg::REQ_SETCUR, 8'h00, 7'h7F, 5'h1F);
    issue(tcw_pkg::REQ_PUT, 8'h7E, 7'd0, 5'd0);
    issue(tcw_pkg::REQ_READ, 8'h00, 7'(COLS - 1), 5'(ROWS - 2));
    issue(tcw_pkg::REQ_SETCUR, 8'h00, 7'd5, 5'(ROWS - 1));
    issue(tcw_pkg::REQ_PUT, tcw_pkg::CH_NEWLINE, 7'd0, 5'd0);
    issue(tcw_pkg::REQ_READ, 8'h00, 7'h7F, 5'h1F);
    issue(REQ_SPARE_LO, 8'hFF, 7'h7F, 5'h1F);
    issue(REQ_SPARE_HI, 8'h00, 7'd0, 5'd0);

    // Extreme colors: new cells, both recolor sweeps and clear.
    drain();
    set_colors(4'h0, 4'hF);
    issue(tcw_pkg::REQ_PUT, 8'h5A, 7'd0, 5'd0);
    issue(tcw_pkg::REQ_READ, 8'h00, 7'd5, 5'(ROWS - 1));
    issue(tcw_pkg::REQ_FG, 8'h00, 7'd0, 5'd0);
    issue(tcw_pkg::REQ_BG, 8'h00, 7'd0, 5'd0);
    issue(tcw_pkg::REQ_READ, 8'h00, 7'(COLS - 1), 5'(ROWS - 3));
    issue(tcw_pkg::REQ_CLEAR, 8'h00, 7'd0, 5'd0);
    issue(tcw_pkg::REQ_READ, 8'h00, 7'd40, 5'd12);

    for (p = 0; p < PHASES; p++) begin
      drain();
      case (p % 3)
        0: set_colors(4'hF, 4'h0);
        1: set_colors(4'h0, 4'hF);
        default: set_colors(4'($urandom), 4'($urandom));
      endcase
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) begin
        gaps_on = (p < PHASES - 1) && ($urandom_range(0, 2) != 0);
        run_sequence();
      end
    end

    drain();
    repeat (8) @(posedge clk);
    $display("Run covered %0d items and %0d results across %0d color register writes.",
             items_sent, sb.reports_seen, sb.color_writes);
    $display("It included %0d cell reads, %0d scrolls, %0d clears or recolors,",
             sb.reads, sb.scrolls, sb.sweeps);
    $display("and %0d clamped coordinates.", sb.clamps);
    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Allows every item to take a full-screen sweep plus the longest gap, several times over.
  initial begin
    #30ms;
    $display("Mismatches found");
    $finish;
  end

endmodule
